// ===== sv/cfhd_pkg.sv =====
`default_nettype none
package cfhd_pkg;

  localparam int MAX_BINS_DEF    = 256;
  localparam int COUNT_WIDTH_DEF = 24;
  localparam int CFG_W           = 9;
  localparam int PIX_W           = 8;
  localparam int FIDX_W          = 32;
  localparam int DIFF_W          = 40;
  localparam logic [CFG_W-1:0] BINS_RESET = 9'd50;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_PRD,
    ST_PWR,
    ST_WALK,
    ST_DIV,
    ST_OUT
  } cfhd_state_t;

  typedef struct packed {
    logic clr;
    logic cap;
    logic pwr;
    logic walk;
    logic wend;
    logic step;
    logic emit;
    logic cnt_rst;
  } cfhd_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic cnt_end;
    logic fe;
    logic have_prev;
    logic div_last;
  } cfhd_sts_t;

endpackage
`default_nettype wire

// ===== sv/color_histogram_frame_difference.sv =====
// channel   ports                                          transfer
// pixel     start, busy, in_blue/green/red, in_frame_end   start & !busy
// result    out_valid, out_frame_index, out_mean_abs_diff  out_valid, one cycle
// config    cfg_valid, cfg_ready, cfg_bins_per_channel     cfg_valid & cfg_ready
//
// a pixel goes through bin index, count read and count write (count memories with one read and one write port)
// frame end adds a bin walk over the count memories, then, once a previous frame exists, the divide and the output
// (dividend width COUNT_WIDTH + clog2(3*MAX_BINS) + 8 bits, one quotient bit a cycle)
// after reset a clearing pass over the current-frame count memories holds busy high
// the receiver cannot stall; each result shows for one cycle
`default_nettype none
module color_histogram_frame_difference
  import cfhd_pkg::*;
#(
  parameter int MAX_BINS    = MAX_BINS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [PIX_W-1:0]  in_blue,
  input  wire logic [PIX_W-1:0]  in_green,
  input  wire logic [PIX_W-1:0]  in_red,
  input  wire logic              in_frame_end,
  output logic                   out_valid,
  output logic [FIDX_W-1:0]      out_frame_index,
  output logic [DIFF_W-1:0]      out_mean_abs_diff,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_W-1:0]  cfg_bins_per_channel
);

  cfhd_cmd_t cmd;
  cfhd_sts_t sts;

  assign cfg_ready = 1'b1;

  cfhd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  cfhd_datapath #(
    .MAX_BINS    (MAX_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_blue              (in_blue),
    .in_green             (in_green),
    .in_red               (in_red),
    .in_frame_end         (in_frame_end),
    .cfg_valid            (cfg_valid),
    .cfg_bins_per_channel (cfg_bins_per_channel),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_valid            (out_valid),
    .out_frame_index      (out_frame_index),
    .out_mean_abs_diff    (out_mean_abs_diff)
  );

endmodule
`default_nettype wire

// ===== sv/cfhd_ctrl.sv =====
`default_nettype none
module cfhd_ctrl
  import cfhd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire cfhd_sts_t sts,
  output cfhd_cmd_t      cmd
);

  cfhd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_CLR: begin
        cmd.clr = 1'b1;
        if (sts.cnt_last) begin
          cmd.cnt_rst = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.cap   = 1'b1;
          state_nxt = ST_PRD;
        end
      end
      ST_PRD: begin
        state_nxt = ST_PWR;
      end
      ST_PWR: begin
        cmd.pwr   = 1'b1;
        state_nxt = sts.fe ? ST_WALK : ST_IDLE;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.cnt_end) begin
          cmd.wend    = 1'b1;
          cmd.cnt_rst = 1'b1;
          state_nxt   = sts.have_prev ? ST_DIV : ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/cfhd_datapath.sv =====
`default_nettype none
module cfhd_datapath
  import cfhd_pkg::*;
#(
  parameter int MAX_BINS    = MAX_BINS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [PIX_W-1:0]  in_blue,
  input  wire logic [PIX_W-1:0]  in_green,
  input  wire logic [PIX_W-1:0]  in_red,
  input  wire logic              in_frame_end,
  input  wire logic              cfg_valid,
  input  wire logic [CFG_W-1:0]  cfg_bins_per_channel,
  input  wire cfhd_cmd_t         cmd,
  output cfhd_sts_t              sts,
  output logic                   out_valid,
  output logic [FIDX_W-1:0]      out_frame_index,
  output logic [DIFF_W-1:0]      out_mean_abs_diff
);

  localparam int AW   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CNTW = AW + 1;
  localparam int BW   = $clog2(MAX_BINS + 1);
  localparam int CW   = COUNT_WIDTH;
  localparam int SW   = CW + $clog2(3 * MAX_BINS);
  localparam int NW   = SW + 8;
  localparam int DW   = BW + 2;
  localparam int DCW  = $clog2(NW + 1);
  localparam int QXW  = (NW > DIFF_W) ? NW : DIFF_W + 1;
  localparam int PW   = PIX_W + BW;

  logic [CFG_W-1:0]  bins_r;
  logic [BW-1:0]     bins_eff;
  logic [CNTW-1:0]   cnt_r;
  logic [AW-1:0]     walk_k;
  logic              walk_wr;
  logic              in_range;
  logic              fe_r;
  logic              have_prev_r;
  logic [FIDX_W-1:0] frame_cnt_r;
  logic [SW-1:0]     sum_r;
  logic [SW-1:0]     sum_tot;
  logic [SW-1:0]     add3;
  logic [NW-1:0]     n_r;
  logic [DW-1:0]     rem_r;
  logic [DCW-1:0]    dcnt_r;
  logic [DW-1:0]     divisor;
  logic [DW:0]       rem2;
  logic              qbit;
  logic [QXW-1:0]    q_ext;
  logic              out_valid_r;
  logic [FIDX_W-1:0] out_idx_r;
  logic [FIDX_W-1:0] idx_hold_r;
  logic [DIFF_W-1:0] out_diff_r;
  logic [PIX_W-1:0]  pix [3];
  logic [AW-1:0]     idx_r [3];
  logic [CW-1:0]     cur_q [3];
  logic [CW-1:0]     prev_q [3];
  logic [CW-1:0]     ad [3];

  assign pix[0] = in_blue;
  assign pix[1] = in_green;
  assign pix[2] = in_red;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_r <= BINS_RESET;
    end else if (cfg_valid) begin
      bins_r <= cfg_bins_per_channel;
    end
  end

  always_comb begin
    priority if (bins_r == '0) begin
      bins_eff = BW'(1);
    end else if (bins_r > CFG_W'(MAX_BINS)) begin
      bins_eff = BW'(MAX_BINS);
    end else begin
      bins_eff = bins_r[BW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_rst) begin
      cnt_r <= '0;
    end else if (cmd.clr || cmd.walk) begin
      cnt_r <= cnt_r + CNTW'(1);
    end
  end

  assign walk_k   = cnt_r[AW-1:0] - AW'(1);
  assign walk_wr  = cmd.walk && (cnt_r != '0);
  assign in_range = BW'(walk_k) < bins_eff;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      fe_r <= in_frame_end;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [CW-1:0] cur_mem  [MAX_BINS];
    logic [CW-1:0] prev_mem [MAX_BINS];
    logic [PW-1:0] prod;
    logic [AW-1:0] cur_ra;
    logic [AW-1:0] cur_wa;
    logic [CW-1:0] cur_wd;
    logic          cur_we;

    assign prod = PW'(pix[c]) * PW'(bins_eff);

    always_ff @(posedge clk) begin
      if (cmd.cap) begin
        idx_r[c] <= prod[PIX_W +: AW];
      end
    end

    always_comb begin
      cur_ra = cmd.walk ? cnt_r[AW-1:0] : idx_r[c];
      cur_we = cmd.clr || cmd.pwr || walk_wr;
      cur_wa = idx_r[c];
      cur_wd = '0;
      priority if (cmd.clr) begin
        cur_wa = cnt_r[AW-1:0];
      end else if (cmd.pwr) begin
        cur_wd = (cur_q[c] == '1) ? cur_q[c] : cur_q[c] + CW'(1);
      end else begin
        cur_wa = walk_k;
      end
    end

    always_ff @(posedge clk) begin
      if (cur_we) begin
        cur_mem[cur_wa] <= cur_wd;
      end
      cur_q[c] <= cur_mem[cur_ra];
    end

    always_ff @(posedge clk) begin
      if (walk_wr) begin
        prev_mem[walk_k] <= cur_q[c];
      end
      prev_q[c] <= prev_mem[cnt_r[AW-1:0]];
    end

    assign ad[c] = (cur_q[c] >= prev_q[c]) ? cur_q[c] - prev_q[c] : prev_q[c] - cur_q[c];
  end

  assign add3    = SW'(ad[0]) + SW'(ad[1]) + SW'(ad[2]);
  assign sum_tot = (walk_wr && in_range) ? sum_r + add3 : sum_r;

  always_ff @(posedge clk) begin
    if (cmd.walk) begin
      sum_r <= (cnt_r == '0) ? '0 : sum_tot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      frame_cnt_r <= '0;
    end else if (cmd.wend) begin
      have_prev_r <= 1'b1;
      frame_cnt_r <= frame_cnt_r + FIDX_W'(1);
    end
  end

  assign divisor = DW'(bins_eff) * DW'(3);
  assign rem2    = {rem_r, n_r[NW-1]};
  assign qbit    = rem2 >= (DW+1)'(divisor);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.wend) begin
      dcnt_r <= '0;
    end else if (cmd.step) begin
      dcnt_r <= dcnt_r + DCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wend) begin
      n_r        <= {sum_tot, 8'h00};
      rem_r      <= '0;
      idx_hold_r <= frame_cnt_r;
    end else if (cmd.step) begin
      n_r   <= {n_r[NW-2:0], qbit};
      rem_r <= qbit ? DW'(rem2 - (DW+1)'(divisor)) : rem2[DW-1:0];
    end
  end

  assign q_ext = QXW'(n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_idx_r  <= idx_hold_r;
      out_diff_r <= (q_ext > QXW'({DIFF_W{1'b1}})) ? '1 : q_ext[DIFF_W-1:0];
    end
  end

  assign sts.cnt_last  = cnt_r == CNTW'(MAX_BINS - 1);
  assign sts.cnt_end   = cnt_r == CNTW'(MAX_BINS);
  assign sts.fe        = fe_r;
  assign sts.have_prev = have_prev_r;
  assign sts.div_last  = dcnt_r == DCW'(NW - 1);

  assign out_valid         = out_valid_r;
  assign out_frame_index   = out_idx_r;
  assign out_mean_abs_diff = out_diff_r;

endmodule
`default_nettype wire
